// File: rtl/sbom_pkg.sv
`default_nettype none

package sbom_pkg;

	localparam int DEF_MAX_OUTER_BOUNDS = 1024;
	localparam int DEF_COORD_BITS       = 18;

	localparam int         SPC_BITS  = 4;
	localparam logic [3:0] SPC_RESET = 4'd3;

	localparam int CMD_BITS  = 2;
	localparam int STAT_BITS = 2;
	localparam int OFF_BITS  = 32;

	localparam logic [1:0] CMD_CLEAR  = 2'd0;
	localparam logic [1:0] CMD_APPEND = 2'd1;
	localparam logic [1:0] CMD_MAP    = 2'd2;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_MISS = 2'd2;
	localparam logic [1:0] ST_OVF  = 2'd3;

	typedef struct packed {
		logic [STAT_BITS-1:0] status;
		logic [OFF_BITS-1:0]  total_cells;
		logic [OFF_BITS-1:0]  offset_prev;
		logic [OFF_BITS-1:0]  offset_cur;
		logic [OFF_BITS-1:0]  offset_next;
	} sbom_result_t;

endpackage

`default_nettype wire

// File: rtl/sbom_ram.sv
`default_nettype none

module sbom_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// File: rtl/sbom_core.sv
`default_nettype none

module sbom_core #(
	parameter int MAX_OUTER_BOUNDS = sbom_pkg::DEF_MAX_OUTER_BOUNDS,
	parameter int COORD_BITS       = sbom_pkg::DEF_COORD_BITS
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               idle,
	input  wire logic [sbom_pkg::CMD_BITS-1:0] cmd,
	input  wire logic [COORD_BITS-1:0]         row,
	input  wire logic [COORD_BITS-1:0]         left_col,
	input  wire logic [COORD_BITS-1:0]         right_col,
	input  wire logic [sbom_pkg::SPC_BITS-1:0] states_per_cell,
	input  wire logic                          out_free,
	output logic                               res_valid,
	output sbom_pkg::sbom_result_t             res
);

	import sbom_pkg::*;

	localparam int CB = COORD_BITS;
	localparam int AW = $clog2(MAX_OUTER_BOUNDS);
	localparam int CW = $clog2(MAX_OUTER_BOUNDS + 1);
	localparam int PW = CB + 1 + SPC_BITS;
	localparam int SW = ((PW > OFF_BITS) ? PW : OFF_BITS) + 1;
	localparam int EW = 3 * CB + OFF_BITS;
	localparam logic [CW-1:0]      FULL_CNT = CW'(MAX_OUTER_BOUNDS);
	localparam logic signed [CB:0] ONE_X    = (CB + 1)'(1);

	typedef enum logic [2:0] {
		IDLE, APP_MUL, APP_ADD, MAP_LD, MAP_CHK, MAP_ADD, FIN
	} state_t;

	state_t         state_q;
	logic [1:0]     cmd_q;
	logic [1:0]     st_q;
	logic [CW-1:0]  count_q;
	logic [31:0]    total_q;
	logic [CW-1:0]  ptr_q [3];
	logic [1:0]     k_q;
	logic           phase2_q;
	logic           miss_q;
	logic           ovf_q;

	logic [CB-1:0]  row_q, left_q, right_q;
	logic [CW-1:0]  p_q;
	logic [PW-1:0]  prod_q;
	logic [31:0]    base_q;
	logic [31:0]    offs_q [3];

	logic [EW-1:0]  rd_data;
	logic [AW-1:0]  rd_addr;
	logic           wr_en;
	logic [EW-1:0]  wr_data;

	logic [CW-1:0]  ptr_sel;
	logic [CW-1:0]  pn;
	logic           pn_end;
	logic signed [CB:0] row_x, left_x, right_x, target;
	logic signed [CB:0] e_row_x, e_lo_x, e_hi_x;
	logic [31:0]    e_off;
	logic           hit_row, contain, app_rev;
	logic signed [CB:0] map_diff, app_diff;
	logic [PW-1:0]  map_prod, app_prod;
	logic [SW-1:0]  app_sum, map_sum;
	logic           app_ovf, map_ovf;
	logic [1:0]     fin_status;

	always_comb begin
		case (k_q)
			2'd0:    ptr_sel = ptr_q[0];
			2'd1:    ptr_sel = ptr_q[1];
			default: ptr_sel = ptr_q[2];
		endcase
	end

	// entry layout, low to high: start offset, right, left, row
	assign e_off   = rd_data[31:0];
	assign e_hi_x  = $signed({rd_data[32+CB-1], rd_data[32+CB-1:32]});
	assign e_lo_x  = $signed({rd_data[32+2*CB-1], rd_data[32+2*CB-1:32+CB]});
	assign e_row_x = $signed({rd_data[32+3*CB-1], rd_data[32+3*CB-1:32+2*CB]});

	assign row_x   = $signed({row_q[CB-1], row_q});
	assign left_x  = $signed({left_q[CB-1], left_q});
	assign right_x = $signed({right_q[CB-1], right_q});
	// k = 0, 1, 2 looks at row - 1, row, row + 1
	assign target  = row_x + $signed({{(CB - 1){1'b0}}, k_q}) - ONE_X;

	assign hit_row  = (e_row_x == target);
	assign contain  = (left_x >= e_lo_x) && (left_x < e_hi_x);
	assign map_diff = left_x - e_lo_x;
	assign map_prod = PW'($unsigned(map_diff)) * PW'(states_per_cell);
	assign map_sum  = SW'(base_q) + SW'(prod_q);
	assign map_ovf  = |map_sum[SW-1:32];

	assign app_rev  = (right_x < left_x);
	assign app_diff = right_x - left_x;
	assign app_prod = PW'($unsigned(app_diff)) * PW'(states_per_cell);
	assign app_sum  = SW'(total_q) + SW'(prod_q);
	assign app_ovf  = |app_sum[SW-1:32];

	assign pn     = p_q + CW'(1);
	assign pn_end = (pn >= count_q);

	assign rd_addr = (state_q == MAP_LD) ? ptr_sel[AW-1:0] : pn[AW-1:0];
	assign wr_en   = (state_q == APP_ADD) && !app_ovf;
	assign wr_data = {row_q, left_q, right_q, total_q};

	sbom_ram #(
		.WIDTH(EW),
		.DEPTH(MAX_OUTER_BOUNDS)
	) u_table (
		.clk  (clk),
		.we   (wr_en),
		.waddr(count_q[AW-1:0]),
		.wdata(wr_data),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	always_comb begin
		if (cmd_q == CMD_MAP) begin
			fin_status = miss_q ? ST_MISS : (ovf_q ? ST_OVF : ST_OK);
		end else begin
			fin_status = st_q;
		end
	end

	assign idle      = (state_q == IDLE);
	assign res_valid = (state_q == FIN) && out_free;
	assign res.status      = fin_status;
	assign res.total_cells = total_q;
	assign res.offset_prev = offs_q[0];
	assign res.offset_cur  = offs_q[1];
	assign res.offset_next = offs_q[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= IDLE;
			cmd_q    <= CMD_CLEAR;
			st_q     <= ST_OK;
			count_q  <= '0;
			total_q  <= '0;
			ptr_q[0] <= '0;
			ptr_q[1] <= '0;
			ptr_q[2] <= '0;
			k_q      <= '0;
			phase2_q <= 1'b0;
			miss_q   <= 1'b0;
			ovf_q    <= 1'b0;
		end else begin
			case (state_q)
				IDLE: begin
					if (start) begin
						cmd_q  <= cmd;
						st_q   <= ST_OK;
						k_q    <= '0;
						miss_q <= 1'b0;
						ovf_q  <= 1'b0;
						case (cmd)
							CMD_CLEAR: begin
								count_q  <= '0;
								total_q  <= '0;
								ptr_q[0] <= '0;
								ptr_q[1] <= '0;
								ptr_q[2] <= '0;
								state_q  <= FIN;
							end
							CMD_APPEND: state_q <= APP_MUL;
							CMD_MAP:    state_q <= MAP_LD;
							default:    state_q <= FIN;
						endcase
					end
				end
				APP_MUL: begin
					if (count_q == FULL_CNT) begin
						st_q    <= ST_FULL;
						state_q <= FIN;
					end else if (app_rev) begin
						st_q    <= ST_OVF;
						state_q <= FIN;
					end else begin
						state_q <= APP_ADD;
					end
				end
				APP_ADD: begin
					if (app_ovf) begin
						st_q <= ST_OVF;
					end else begin
						count_q  <= count_q + CW'(1);
						total_q  <= app_sum[31:0];
						ptr_q[0] <= '0;
						ptr_q[1] <= '0;
						ptr_q[2] <= '0;
					end
					state_q <= FIN;
				end
				MAP_LD: begin
					phase2_q <= 1'b0;
					if (ptr_sel >= count_q) begin
						miss_q <= 1'b1;
						if (k_q == 2'd2) begin
							state_q <= FIN;
						end else begin
							k_q     <= k_q + 2'd1;
							state_q <= MAP_LD;
						end
					end else begin
						state_q <= MAP_CHK;
					end
				end
				MAP_CHK: begin
					if ((phase2_q || hit_row) && contain) begin
						ptr_q[k_q] <= p_q;
						state_q    <= MAP_ADD;
					end else begin
						// row phase ends at the first entry of the target row
						if (phase2_q || hit_row) begin
							phase2_q <= 1'b1;
						end
						if (pn_end) begin
							ptr_q[k_q] <= count_q;
							miss_q     <= 1'b1;
							if (k_q == 2'd2) begin
								state_q <= FIN;
							end else begin
								k_q     <= k_q + 2'd1;
								state_q <= MAP_LD;
							end
						end
					end
				end
				MAP_ADD: begin
					if (map_ovf) begin
						ovf_q <= 1'b1;
					end
					if (k_q == 2'd2) begin
						state_q <= FIN;
					end else begin
						k_q     <= k_q + 2'd1;
						state_q <= MAP_LD;
					end
				end
				FIN: begin
					if (out_free) begin
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		case (state_q)
			IDLE: begin
				if (start) begin
					row_q     <= row;
					left_q    <= left_col;
					right_q   <= right_col;
					offs_q[0] <= '0;
					offs_q[1] <= '0;
					offs_q[2] <= '0;
				end
			end
			APP_MUL: prod_q <= app_prod;
			MAP_LD:  p_q <= ptr_sel;
			MAP_CHK: begin
				if ((phase2_q || hit_row) && contain) begin
					prod_q <= map_prod;
					base_q <= e_off;
				end else begin
					p_q <= pn;
				end
			end
			MAP_ADD: begin
				offs_q[k_q] <= map_ovf ? 32'hFFFF_FFFF : map_sum[31:0];
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/sparse_band_offset_mapper.sv
`default_nettype none
// Accept to result beat on m_*: clear and unused command go to FIN, append via APP_MUL and
// APP_ADD, map via three searches. A search reads one table entry per cycle: MAP_LD loads
// its pointer, MAP_CHK checks each entry, MAP_ADD adds the offset on a hit; only MAP_LD if
// the pointer is at the table end. One item is worked at a time; s_tready rises once its
// result is in the output register. arst_n clears control state and the cell total;
// states_per_cell resets to 3; table memory is not cleared (reads stay below the count).

module sparse_band_offset_mapper #(
	parameter int MAX_OUTER_BOUNDS = sbom_pkg::DEF_MAX_OUTER_BOUNDS,
	parameter int COORD_BITS       = sbom_pkg::DEF_COORD_BITS
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_we,
	input  wire logic [sbom_pkg::SPC_BITS-1:0]          cfg_wdata,  // states_per_cell
	input  wire logic                                   s_tvalid,
	output logic                                        s_tready,
	// row, left_col, right_col
	input  wire logic [((3 * COORD_BITS + 7) / 8) * 8-1:0] s_tdata,
	input  wire logic [sbom_pkg::CMD_BITS-1:0]          s_tuser,    // command
	output logic                                        m_tvalid,
	input  wire logic                                   m_tready,
	// total_cells, offset_prev, offset_cur, offset_next
	output logic [4 * sbom_pkg::OFF_BITS-1:0]           m_tdata,
	output logic [sbom_pkg::STAT_BITS-1:0]              m_tuser     // status
);

	import sbom_pkg::*;

	localparam int CB = COORD_BITS;

	logic [SPC_BITS-1:0] states_per_cell_q;
	logic                core_idle;
	logic                out_free;
	logic                res_valid;
	sbom_result_t        res;

	assign out_free = !m_tvalid || m_tready;
	assign s_tready = core_idle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			states_per_cell_q <= SPC_RESET;
		end else if (cfg_we) begin
			states_per_cell_q <= cfg_wdata;
		end
	end

	sbom_core #(
		.MAX_OUTER_BOUNDS(MAX_OUTER_BOUNDS),
		.COORD_BITS      (COORD_BITS)
	) u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (s_tvalid && s_tready),
		.idle           (core_idle),
		.cmd            (s_tuser),
		.row            (s_tdata[CB-1:0]),
		.left_col       (s_tdata[2*CB-1:CB]),
		.right_col      (s_tdata[3*CB-1:2*CB]),
		.states_per_cell(states_per_cell_q),
		.out_free       (out_free),
		.res_valid      (res_valid),
		.res            (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (res_valid) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			m_tuser <= res.status;
			m_tdata <= {res.offset_next, res.offset_cur, res.offset_prev, res.total_cells};
		end
	end

endmodule

`default_nettype wire

// File: test/sparse_band_offset_mapper_tb.sv
`timescale 1ns / 1ps

module sparse_band_offset_mapper_tb;
	import sbom_pkg::*;

	localparam int CW      = DEF_COORD_BITS;
	localparam int MAXB    = DEF_MAX_OUTER_BOUNDS;
	localparam int TDW     = ((3 * CW + 7) / 8) * 8;
	localparam int CMIN_I  = -(1 << (CW - 1));
	localparam int CMAX_I  = (1 << (CW - 1)) - 1;
	localparam int N_ITEMS = 1850;
	localparam int HOLD_AT  = 3000;
	localparam int HOLD_LEN = 600;

	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam logic [CW-1:0] C_MIN    = 18'h20000;
	localparam logic [CW-1:0] C_MIN_P1 = 18'h20001;
	localparam logic [CW-1:0] C_MAX    = 18'h1FFFF;
	localparam logic [CW-1:0] C_NEG1   = 18'h3FFFF;

	typedef struct packed {
		logic [1:0]    cmd;
		logic [CW-1:0] row;
		logic [CW-1:0] lft;
		logic [CW-1:0] rgt;
		logic          typed;
		logic [1:0]    st;
		logic [31:0]   tot;
	} stim_row_t;

	// states_per_cell is 3 out of reset for all of these
	localparam stim_row_t DIRECTED [24] = '{
		'{CMD_MAP,    18'd0,    18'd0,  18'd0,    1'b1, ST_MISS, 32'd0},
		'{CMD_UNUSED, C_MAX,    C_MIN,  C_NEG1,   1'b1, ST_OK,   32'd0},
		'{CMD_CLEAR,  18'd0,    18'd0,  18'd0,    1'b1, ST_OK,   32'd0},
		'{CMD_APPEND, 18'd0,    18'd0,  18'd10,   1'b1, ST_OK,   32'd30},
		'{CMD_APPEND, 18'd1,    18'd2,  18'd12,   1'b1, ST_OK,   32'd60},
		'{CMD_APPEND, 18'd2,    18'd0,  18'd5,    1'b1, ST_OK,   32'd75},
		'{CMD_APPEND, 18'd3,    18'd5,  18'd4,    1'b1, ST_OVF,  32'd75},
		'{CMD_APPEND, 18'd3,    18'd7,  18'd7,    1'b1, ST_OK,   32'd75},
		'{CMD_MAP,    18'd1,    18'd3,  18'd0,    1'b0, ST_OK,   32'd0},
		'{CMD_MAP,    18'd1,    18'd4,  C_NEG1,   1'b0, ST_OK,   32'd0},
		'{CMD_MAP,    18'd1,    18'd11, 18'd0,    1'b0, ST_OK,   32'd0},
		'{CMD_MAP,    18'd0,    18'd3,  18'd0,    1'b0, ST_OK,   32'd0},
		'{CMD_APPEND, C_MIN,    C_MIN,  C_MAX,    1'b0, ST_OK,   32'd0},
		'{CMD_APPEND, C_MAX,    C_MAX,  C_MIN,    1'b0, ST_OK,   32'd0},
		'{CMD_MAP,    C_MIN_P1, C_NEG1, C_MAX,    1'b0, ST_OK,   32'd0},
		'{CMD_MAP,    C_MAX,    C_MAX,  C_MIN,    1'b0, ST_OK,   32'd0},
		'{CMD_CLEAR,  C_NEG1,   C_NEG1, C_NEG1,   1'b1, ST_OK,   32'd0},
		'{CMD_APPEND, 18'd0,    18'd0,  18'd4,    1'b1, ST_OK,   32'd12},
		'{CMD_APPEND, 18'd1,    18'd0,  18'd4,    1'b1, ST_OK,   32'd24},
		'{CMD_APPEND, 18'd2,    18'd10, 18'd20,   1'b1, ST_OK,   32'd54},
		// column walk runs past row 1 and lands on the row 2 span
		'{CMD_MAP,    18'd1,    18'd12, 18'd0,    1'b0, ST_OK,   32'd0},
		// pointers never move back, so an earlier row now misses
		'{CMD_MAP,    18'd0,    18'd0,  18'd0,    1'b0, ST_OK,   32'd0},
		'{CMD_CLEAR,  18'd0,    18'd0,  18'd0,    1'b1, ST_OK,   32'd0},
		'{CMD_MAP,    18'd5,    18'd5,  18'd5,    1'b1, ST_MISS, 32'd0}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [SPC_BITS-1:0] cfg_wdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [TDW-1:0] s_tdata = '0;
	logic [CMD_BITS-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [4*OFF_BITS-1:0] m_tdata;
	logic [STAT_BITS-1:0] m_tuser;

	sparse_band_offset_mapper dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #10 clk = ~clk;

	// shadow of the bound table and search state
	int          tbl_row [MAXB];
	int          tbl_lo [MAXB];
	int          tbl_hi [MAXB];
	logic [31:0] tbl_base [MAXB];
	int          tbl_count = 0;
	logic [31:0] cell_sum = '0;
	int          walk_ptr [3] = '{0, 0, 0};
	int          spc_val = int'(SPC_RESET);

	sbom_result_t offsets_q[$];
	int errors = 0;
	int n_sent = 0;
	int burst_left = 0;
	int gap_max = 4;
	bit filled = 1'b0;

	function automatic logic [CW-1:0] to_coord(input int v);
		return v[CW-1:0];
	endfunction

	function automatic logic [1:0] walk_search(input int k, input int target, input int col,
			output logic [31:0] off);
		int p;
		longint sum;
		p = walk_ptr[k];
		if (p > tbl_count)
			p = tbl_count;
		while (p < tbl_count && tbl_row[p] != target)
			p++;
		while (p < tbl_count && !(col >= tbl_lo[p] && col < tbl_hi[p]))
			p++;
		walk_ptr[k] = p;
		off = '0;
		if (p >= tbl_count)
			return ST_MISS;
		sum = longint'({32'd0, tbl_base[p]}) + longint'(col - tbl_lo[p]) * longint'(spc_val);
		if (sum > 64'd4294967295) begin
			off = '1;
			return ST_OVF;
		end
		off = sum[31:0];
		return ST_OK;
	endfunction

	function automatic sbom_result_t map_offsets(input logic [1:0] cmd,
			input logic [CW-1:0] row_f, input logic [CW-1:0] lft_f, input logic [CW-1:0] rgt_f);
		sbom_result_t res;
		int row_i, lft_i, rgt_i, k;
		longint grown;
		logic [1:0] st;
		logic [31:0] off [3];
		bit miss, ovf;
		res = '0;
		row_i = $signed(row_f);
		lft_i = $signed(lft_f);
		rgt_i = $signed(rgt_f);
		miss = 1'b0;
		ovf = 1'b0;
		off = '{32'd0, 32'd0, 32'd0};
		case (cmd)
			CMD_CLEAR: begin
				tbl_count = 0;
				cell_sum = '0;
				walk_ptr = '{0, 0, 0};
			end
			CMD_APPEND: begin
				if (tbl_count >= MAXB) begin
					res.status = ST_FULL;
				end else if (rgt_i < lft_i) begin
					res.status = ST_OVF;
				end else begin
					grown = longint'({32'd0, cell_sum}) + longint'(rgt_i - lft_i) * longint'(spc_val);
					if (grown > 64'd4294967295) begin
						res.status = ST_OVF;
					end else begin
						tbl_row[tbl_count] = row_i;
						tbl_lo[tbl_count] = lft_i;
						tbl_hi[tbl_count] = rgt_i;
						tbl_base[tbl_count] = cell_sum;
						tbl_count++;
						cell_sum = grown[31:0];
						walk_ptr = '{0, 0, 0};
					end
				end
			end
			CMD_MAP: begin
				for (k = 0; k < 3; k++) begin
					st = walk_search(k, row_i + k - 1, lft_i, off[k]);
					if (st == ST_MISS)
						miss = 1'b1;
					else if (st == ST_OVF)
						ovf = 1'b1;
				end
				res.status = miss ? ST_MISS : (ovf ? ST_OVF : ST_OK);
			end
			default: ;
		endcase
		res.total_cells = cell_sum;
		res.offset_prev = off[0];
		res.offset_cur = off[1];
		res.offset_next = off[2];
		return res;
	endfunction

	// called at a falling edge, returns at a falling edge with tvalid low
	task automatic send_item(input logic [1:0] cmd, input logic [CW-1:0] row_f,
			input logic [CW-1:0] lft_f, input logic [CW-1:0] rgt_f, input bit typed = 1'b0,
			input logic [1:0] t_st = ST_OK, input logic [31:0] t_tot = '0);
		sbom_result_t want;
		if (burst_left == 0) begin
			repeat ($urandom_range(0, gap_max)) @(negedge clk);
			burst_left = $urandom_range(1, 24);
		end
		s_tuser = cmd;
		s_tdata = TDW'({rgt_f, lft_f, row_f});
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		want = map_offsets(cmd, row_f, lft_f, rgt_f);
		if (typed) begin
			want = '0;
			want.status = t_st;
			want.total_cells = t_tot;
		end
		offsets_q.push_back(want);
		n_sent++;
		burst_left--;
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task automatic set_spc(input int v);
		while (offsets_q.size() != 0)
			@(negedge clk);
		cfg_wdata = v[SPC_BITS-1:0];
		cfg_we = 1'b1;
		@(negedge clk);
		cfg_we = 1'b0;
		spc_val = v & 15;
	endtask

	task automatic noise_item();
		logic [1:0] cmd;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: cmd = CMD_MAP;
			4, 5, 6: cmd = CMD_UNUSED;
			7, 8: cmd = CMD_APPEND;
			default: cmd = CMD_CLEAR;
		endcase
		send_item(cmd, CW'($urandom), CW'($urandom), CW'($urandom));
	endtask

	// clear, build a small banded table, then walk it with maps
	task automatic band_sequence();
		int span_row[$];
		int span_lo[$];
		int span_hi[$];
		int n_rows, row_i, col, w, j, lc, rr;
		send_item(CMD_CLEAR, '0, '0, '0);
		n_rows = $urandom_range(1, 8);
		case ($urandom_range(0, 9))
			0: row_i = CMIN_I + int'($urandom_range(0, 2));
			1: row_i = CMAX_I - n_rows - int'($urandom_range(0, 2));
			default: row_i = int'($urandom_range(0, 400)) - 200;
		endcase
		repeat (n_rows) begin
			case ($urandom_range(0, 9))
				0: col = CMIN_I;
				1: col = CMAX_I - 300;
				default: col = int'($urandom_range(0, 600)) - 300;
			endcase
			repeat ($urandom_range(1, 4)) begin
				w = ($urandom_range(0, 7) == 0) ? 0 : int'($urandom_range(1, 40));
				span_row.push_back(row_i);
				span_lo.push_back(col);
				span_hi.push_back(col + w);
				send_item(CMD_APPEND, to_coord(row_i), to_coord(col), to_coord(col + w));
				if ($urandom_range(0, 99) < 6)
					noise_item();
				col += w + int'($urandom_range(0, 10));
			end
			row_i += ($urandom_range(0, 5) == 0) ? 2 : 1;
		end
		j = 0;
		repeat ($urandom_range(4, 20)) begin
			if ($urandom_range(0, 19) == 0)
				j = $urandom_range(0, span_lo.size() - 1);
			else
				j += int'($urandom_range(0, 1));
			if (j >= span_lo.size())
				j = span_lo.size() - 1;
			lc = span_lo[j];
			if (span_hi[j] > span_lo[j])
				lc += int'($urandom_range(0, span_hi[j] - span_lo[j] - 1));
			if ($urandom_range(0, 9) == 0)
				lc = span_lo[j] + int'($urandom_range(0, 8)) - 4;
			rr = span_row[j];
			if ($urandom_range(0, 9) == 0)
				rr += int'($urandom_range(0, 2)) - 1;
			send_item(CMD_MAP, to_coord(rr), to_coord(lc), CW'($urandom));
			if ($urandom_range(0, 99) < 6)
				noise_item();
		end
	endtask

	// fill the table to the limit, push past it, then a few long searches
	task automatic fill_sequence();
		int i, row0, row_i, col, w;
		send_item(CMD_CLEAR, '0, '0, '0);
		row0 = $urandom_range(0, 100);
		row_i = row0;
		col = 0;
		for (i = 0; i < MAXB + 3; i++) begin
			if ($urandom_range(0, 2) == 0) begin
				row_i++;
				col = $urandom_range(0, 50);
			end
			w = $urandom_range(0, 30);
			send_item(CMD_APPEND, to_coord(row_i), to_coord(col), to_coord(col + w));
			col += w + int'($urandom_range(0, 3));
		end
		repeat (10)
			send_item(CMD_MAP, to_coord(int'($urandom_range(row0, row_i))),
				to_coord(int'($urandom_range(0, 200))), '0);
		send_item(CMD_CLEAR, '0, '0, '0);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin : result_check
		sbom_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (offsets_q.size() == 0) begin
				$error("result beat with nothing outstanding");
				errors++;
			end else begin
				want = offsets_q.pop_front();
				check_field("status", 32'(want.status), 32'(m_tuser));
				check_field("total_cells", want.total_cells, m_tdata[31:0]);
				check_field("offset_prev", want.offset_prev, m_tdata[63:32]);
				check_field("offset_cur", want.offset_cur, m_tdata[95:64]);
				check_field("offset_next", want.offset_next, m_tdata[127:96]);
			end
		end
	end

	// receiver: random stall patterns in runs of random length, one long hold-off
	initial begin : receiver
		int mode, cyc;
		logic [15:0] pat;
		cyc = 0;
		wait (arst_n);
		forever begin
			mode = $urandom_range(0, 2);
			pat = $urandom;
			repeat ($urandom_range(50, 400)) begin
				@(negedge clk);
				cyc++;
				if (cyc >= HOLD_AT && cyc < HOLD_AT + HOLD_LEN)
					m_tready = 1'b0;
				else case (mode)
					0: m_tready = 1'b1;
					1: m_tready = ($urandom_range(0, 3) != 0);
					default: m_tready = pat[cyc % 16];
				endcase
			end
		end
	end

	initial begin : stimulus
		int i, p, v;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		for (i = 0; i < 24; i++)
			send_item(DIRECTED[i].cmd, DIRECTED[i].row, DIRECTED[i].lft, DIRECTED[i].rgt,
				DIRECTED[i].typed, DIRECTED[i].st, DIRECTED[i].tot);
		p = 0;
		while (n_sent < N_ITEMS) begin
			case (p)
				0: v = 15;
				1: v = 0;
				2: v = 1;
				3: v = 8;
				default: v = $urandom_range(0, 15);
			endcase
			set_spc(v);
			gap_max = (p % 3 == 0) ? 0 : int'($urandom_range(1, 8));
			if (!filled && n_sent >= 700) begin
				fill_sequence();
				filled = 1'b1;
			end
			repeat ($urandom_range(1, 4))
				band_sequence();
			p++;
		end
		while (offsets_q.size() != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin : watchdog
		#40_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
